### hw/rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue.
// Holds the operation and status encodings used by the top level.
// No dependencies.
package deq_pkg;

	localparam int KIND_W   = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [KIND_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_CLEAR      = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

endpackage

### hw/rtl/deq_ram.sv
// Generic synchronous RAM: one write port and two read ports.
// Read data is registered and returns the old contents on a same-address write.
// No dependencies.
module deq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### hw/rtl/double_ended_queue.sv
// Double-ended queue kept as a ring buffer in a two-read-port RAM.
// An accepted request moves to a read state while the RAM reads the new front and back
// entries; the result register is loaded on leaving it. No new request is taken in the
// read state or while an earlier result is held on the output and not taken. Reset
// clears the head pointer and the element count; the RAM contents are not cleared.
// Depends on deq_pkg and deq_ram.
module double_ended_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// value
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
	// kind
	input  logic [deq_pkg::KIND_W-1:0]           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// front_value, back_value, count, empty_res, status
	output logic [((2*DATA_WIDTH+$clog2(DEPTH+1)+1+deq_pkg::STATUS_W+7)/8)*8-1:0]
	                                             m_tdata
);
	import deq_pkg::*;

	localparam int AW       = $clog2(DEPTH);
	localparam int CW       = $clog2(DEPTH + 1);
	localparam int SW       = AW + 1;
	localparam int OUT_BITS = 2 * DATA_WIDTH + CW + 1 + STATUS_W;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic                  accept;

	// Next-state values of the accepted request.
	op_t                   op;
	logic [DATA_WIDTH-1:0] value;
	logic [AW-1:0]         head_inc;
	logic [AW-1:0]         head_dec;
	logic [AW-1:0]         tail_pos;
	logic [AW-1:0]         head_n;
	logic [CW-1:0]         count_n;
	status_t               status_n;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [AW-1:0]         back_addr;

	// Stage one: waiting on the RAM read.
	logic [CW-1:0]         count_s1;
	status_t               status_s1;
	logic                  fwd_front_s1;
	logic                  fwd_back_s1;
	logic [DATA_WIDTH-1:0] wdata_s1;
	logic [DATA_WIDTH-1:0] rdata_front;
	logic [DATA_WIDTH-1:0] rdata_back;

	// Output register.
	logic [DATA_WIDTH-1:0] front_q;
	logic [DATA_WIDTH-1:0] back_q;
	logic [CW-1:0]         count_out_q;
	logic                  empty_q;
	status_t               status_q;

	function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
		return r[AW-1:0];
	endfunction

	assign s_tready = (state_q == S_IDLE) && (!m_tvalid || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);
	assign value    = s_tdata[DATA_WIDTH-1:0];

	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign tail_pos = wrap(SW'(head_q) + SW'(count_q));

	always_comb begin
		head_n   = head_q;
		count_n  = count_q;
		status_n = ST_OK;
		we       = 1'b0;
		waddr    = tail_pos;
		unique case (op)
			OP_PUSH_BACK: begin
				if (count_q == CW'(DEPTH)) begin
					status_n = ST_OVER;
				end else begin
					we      = 1'b1;
					count_n = count_q + 1'b1;
				end
			end
			OP_PUSH_FRONT: begin
				waddr = head_dec;
				if (count_q == CW'(DEPTH)) begin
					status_n = ST_OVER;
				end else begin
					we      = 1'b1;
					head_n  = head_dec;
					count_n = count_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (count_q == '0) begin
					status_n = ST_UNDER;
				end else begin
					head_n  = head_inc;
					count_n = count_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (count_q == '0) begin
					status_n = ST_UNDER;
				end else begin
					count_n = count_q - 1'b1;
				end
			end
			OP_CLEAR: begin
				head_n  = '0;
				count_n = '0;
			end
			default: begin
			end
		endcase
	end

	// When the queue is empty this address is meaningless; the result masks it.
	assign back_addr = wrap(SW'(head_n) + SW'(count_n) - 1'b1);

	deq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (accept && we),
		.waddr   (waddr),
		.wdata   (value),
		.raddr_a (head_n),
		.raddr_b (back_addr),
		.rdata_a (rdata_front),
		.rdata_b (rdata_back)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						head_q  <= head_n;
						count_q <= count_n;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					m_tvalid <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The RAM returns old data on a same-cycle write, so the pushed value is
	// forwarded when it lands on the front or back position.
	always_ff @(posedge clk) begin
		if (accept) begin
			count_s1     <= count_n;
			status_s1    <= status_n;
			wdata_s1     <= value;
			fwd_front_s1 <= we && (waddr == head_n);
			fwd_back_s1  <= we && (waddr == back_addr);
		end
		if (state_q == S_READ) begin
			if (count_s1 == '0) begin
				front_q <= '0;
				back_q  <= '0;
			end else begin
				front_q <= fwd_front_s1 ? wdata_s1 : rdata_front;
				back_q  <= fwd_back_s1 ? wdata_s1 : rdata_back;
			end
			count_out_q <= count_s1;
			empty_q     <= (count_s1 == '0);
			status_q    <= status_s1;
		end
	end

	always_comb begin
		m_tdata                 = '0;
		m_tdata[OUT_BITS-1:0]   = {status_q, empty_q, count_out_q, back_q, front_q};
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CW'(DEPTH)) && (head_q <= AW'(DEPTH - 1)))
		else $error("queue pointer or count out of range");

	a_accept_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_READ) && !m_tvalid)
		else $error("accepted request did not move to the read cycle");

	a_result_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_READ))
		else $error("result raised without a read cycle");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_q == ST_UNDER) |-> (empty_q && count_out_q == '0))
		else $error("underflow reported on a non-empty queue");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && empty_q) |-> (front_q == '0 && back_q == '0))
		else $error("empty queue reported non-zero elements");

endmodule
